/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

/* design/stp_pkg.sv */
// ----------------------------------------------------------------------------
// stp_pkg
// Types and constants shared by the sorted timer pool modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

    localparam int unsigned MAX_EXPIRE  = 32;
    localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;

    localparam logic [2:0] FN_TICK   = 3'd0;
    localparam logic [2:0] FN_ALLOC  = 3'd1;
    localparam logic [2:0] FN_FREE   = 3'd2;
    localparam logic [2:0] FN_INIT   = 3'd3;
    localparam logic [2:0] FN_SET    = 3'd4;
    localparam logic [2:0] FN_CANCEL = 3'd5;

    localparam logic [2:0] KIND_ACK      = 3'd0;
    localparam logic [2:0] KIND_ALLOC    = 3'd1;
    localparam logic [2:0] KIND_NOSLOT   = 3'd2;
    localparam logic [2:0] KIND_EXPIRY   = 3'd3;
    localparam logic [2:0] KIND_SWITCH   = 3'd4;
    localparam logic [2:0] KIND_CANCEL   = 3'd5;
    localparam logic [2:0] KIND_NOTRUN   = 3'd6;

    localparam logic [1:0] SS_FREE  = 2'd0;
    localparam logic [1:0] SS_ALLOC = 2'd1;
    localparam logic [1:0] SS_RUN   = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [4:0]  slot;
        logic [31:0] timeout;
        logic [3:0]  queue_id;
        logic [31:0] payload;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  out_slot;
        logic [3:0]  out_queue_id;
        logic [31:0] out_payload;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_TICK, OP_ALLOC, OP_FREE, OP_INIT, OP_SET, OP_CANCEL, OP_NOP
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        ok;
        logic [4:0]  slot;
        logic [31:0] timeout;
        logic [3:0]  queue_id;
        logic [31:0] payload;
    } cmd_t;

    function automatic out_item_t mk_res(logic [2:0] kind, logic [4:0] s,
                                         logic [3:0] q, logic [31:0] p);
        out_item_t r;
        r.kind         = kind;
        r.out_slot     = s;
        r.out_queue_id = q;
        r.out_payload  = p;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/stp_ram.sv */
// ----------------------------------------------------------------------------
// stp_ram
// Generic one-write, one-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

/* design/stp_front.sv */
// ----------------------------------------------------------------------------
// stp_front
// Accepts input items, decodes them into commands and buffers two of them.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_front #(
    parameter int TIMER_SLOTS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire stp_pkg::in_item_t in_item,
    output logic                   cmd_valid,
    output stp_pkg::cmd_t          cmd,
    input  wire logic              cmd_take
);
    import stp_pkg::*;

    cmd_t       dec;
    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    always_comb
    begin
        dec.slot     = in_item.slot;
        dec.timeout  = in_item.timeout;
        dec.queue_id = in_item.queue_id;
        dec.payload  = in_item.payload;
        dec.ok       = (32'(in_item.slot) < TIMER_SLOTS);
        case (in_item.func)
            FN_TICK:   dec.op = OP_TICK;
            FN_ALLOC:  dec.op = OP_ALLOC;
            FN_FREE:   dec.op = OP_FREE;
            FN_INIT:   dec.op = OP_INIT;
            FN_SET:    dec.op = OP_SET;
            FN_CANCEL: dec.op = OP_CANCEL;
            default:   dec.op = OP_NOP;
        endcase
    end

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    // queue storage carries no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(cmd_take);
        end
    end

endmodule

`default_nettype wire

/* design/stp_back.sv */
// ----------------------------------------------------------------------------
// stp_back
// Executes timer commands: slot table, sorted list walks, tick expiry.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_back #(
    parameter int TIMER_SLOTS   = 32,
    parameter int QUEUE_ID_BITS = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire stp_pkg::cmd_t      cmd,
    output logic                    cmd_take,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [5:0]         cfg_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output stp_pkg::out_item_t      out_item
);
    import stp_pkg::*;

    localparam int AW    = $clog2(TIMER_SLOTS);
    localparam int LW    = $clog2(TIMER_SLOTS + 1);
    localparam int MSG_W = QUEUE_ID_BITS + 32;
    localparam logic [LW-1:0] NULL_IDX = LW'(TIMER_SLOTS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_PUSH, ST_FINISH,
        ST_TK_RD, ST_TK_CMP, ST_TK_END,
        ST_RF_RD, ST_RF_WAIT, ST_AL_SCAN,
        ST_UL_START, ST_UL_LS, ST_UL_RD, ST_UL_CMP, ST_UL_DONE,
        ST_IN_START, ST_IN_RD, ST_IN_CMP, ST_IN_LNK, ST_IN_PRV
    } state_t;

    state_t          state_reg, state_next, ret_reg, ret_next, post_reg, post_next;
    cmd_t            cur_reg, cur_next;
    logic [31:0]     tc_reg, tc_next, next_dl_reg, next_dl_next, dval_reg, dval_next;
    logic [LW-1:0]   active_reg, active_next, head_reg, head_next;
    logic [LW-1:0]   ptr_reg, ptr_next, prev_reg, prev_next, ls_reg, ls_next;
    logic [LW-1:0]   walk_reg, walk_next;
    logic [5:0]      exp_reg, exp_next, ts_reg, ts_next;
    logic            tsf_reg, tsf_next;
    logic [AW-1:0]   scan_reg, scan_next;
    logic [1:0]      ss_reg [TIMER_SLOTS];
    logic [1:0]      ss_next [TIMER_SLOTS];
    out_item_t       new_res_reg, new_res_next, hold_reg, hold_next, out_reg, out_next;
    logic            hold_valid_reg, hold_valid_next, out_valid_reg, out_valid_next;

    logic            dl_we, lk_we, mg_we;
    logic [AW-1:0]   dl_waddr, dl_raddr, lk_waddr, lk_raddr, mg_waddr, mg_raddr;
    logic [31:0]     dl_wdata, dl_rd;
    logic [LW-1:0]   lk_wdata, lk_rd;
    logic [MSG_W-1:0] mg_wdata, mg_rd;

    logic [AW-1:0]   s_idx;
    logic [LW-1:0]   s_lw;
    logic            out_free, push_room;

    stp_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_dl_ram (
        .clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
        .raddr(dl_raddr), .rdata(dl_rd)
    );
    stp_ram #(.WIDTH(LW), .DEPTH(TIMER_SLOTS)) u_lk_ram (
        .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
        .raddr(lk_raddr), .rdata(lk_rd)
    );
    stp_ram #(.WIDTH(MSG_W), .DEPTH(TIMER_SLOTS)) u_mg_ram (
        .clk(clk), .we(mg_we), .waddr(mg_waddr), .wdata(mg_wdata),
        .raddr(mg_raddr), .rdata(mg_rd)
    );

    assign s_idx     = AW'(cur_reg.slot);
    assign s_lw      = LW'(cur_reg.slot);
    assign out_free  = !out_valid_reg || !out_stall;
    assign push_room = !hold_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        post_next       = post_reg;
        cur_next        = cur_reg;
        tc_next         = tc_reg;
        next_dl_next    = next_dl_reg;
        dval_next       = dval_reg;
        active_next     = active_reg;
        head_next       = head_reg;
        ptr_next        = ptr_reg;
        prev_next       = prev_reg;
        ls_next         = ls_reg;
        walk_next       = walk_reg;
        exp_next        = exp_reg;
        ts_next         = ts_reg;
        tsf_next        = tsf_reg;
        scan_next       = scan_reg;
        ss_next         = ss_reg;
        new_res_next    = new_res_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        cmd_take        = 1'b0;
        dl_we = 1'b0; dl_waddr = s_idx; dl_wdata = dval_reg; dl_raddr = AW'(head_reg);
        lk_we = 1'b0; lk_waddr = s_idx; lk_wdata = ptr_reg;  lk_raddr = AW'(head_reg);
        mg_we = 1'b0; mg_waddr = s_idx; mg_raddr = AW'(head_reg);
        mg_wdata = {QUEUE_ID_BITS'(cur_reg.queue_id), cur_reg.payload};

        if (cfg_valid)
        begin
            ts_next = cfg_data;
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    cur_next   = cmd;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_FINISH;
                case (cur_reg.op)
                    OP_TICK:
                    begin
                        tc_next = tc_reg + 32'd1;
                        if (!(next_dl_reg > tc_reg + 32'd1))
                        begin
                            exp_next   = 6'd0;
                            tsf_next   = 1'b0;
                            state_next = ST_TK_RD;
                        end
                    end
                    OP_ALLOC:
                    begin
                        scan_next  = '0;
                        state_next = ST_AL_SCAN;
                    end
                    OP_FREE:
                    begin
                        if (cur_reg.ok)
                        begin
                            if (ss_reg[s_idx] == SS_RUN)
                                state_next = ST_UL_START;
                            else
                                ss_next[s_idx] = SS_FREE;
                        end
                    end
                    OP_INIT:
                    begin
                        mg_we = cur_reg.ok;
                    end
                    OP_SET:
                    begin
                        if (cur_reg.ok)
                            state_next = (ss_reg[s_idx] == SS_RUN) ? ST_UL_START
                                                                    : ST_IN_START;
                    end
                    OP_CANCEL:
                    begin
                        if (cur_reg.ok && ss_reg[s_idx] == SS_RUN)
                        begin
                            state_next = ST_UL_START;
                        end
                        else
                        begin
                            new_res_next = mk_res(KIND_NOTRUN, 5'd0, 4'd0, 32'd0);
                            ret_next     = ST_FINISH;
                            state_next   = ST_PUSH;
                        end
                    end
                    default: state_next = ST_FINISH;
                endcase
            end
            // the newest result waits in hold until we know whether it is the last
            ST_PUSH:
            begin
                if (push_room)
                begin
                    if (hold_valid_reg)
                    begin
                        out_next       = hold_reg;
                        out_valid_next = 1'b1;
                    end
                    hold_next       = new_res_reg;
                    hold_valid_next = 1'b1;
                    state_next      = ret_reg;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_next        = hold_valid_reg ? hold_reg
                                                     : mk_res(KIND_ACK, 5'd0, 4'd0, 32'd0);
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_TK_RD:
            begin
                if (32'(exp_reg) < MAX_EXPIRE && 32'(head_reg) < TIMER_SLOTS)
                begin
                    state_next = ST_TK_CMP;
                end
                else
                begin
                    post_next  = ST_TK_END;
                    state_next = ST_RF_RD;
                end
            end
            ST_TK_CMP:
            begin
                if (dl_rd > tc_reg)
                begin
                    next_dl_next = dl_rd;
                    state_next   = ST_TK_END;
                end
                else
                begin
                    ss_next[AW'(head_reg)] = SS_ALLOC;
                    head_next = lk_rd;
                    if (active_reg != '0)
                        active_next = active_reg - LW'(1);
                    exp_next = exp_reg + 6'd1;
                    if (32'(head_reg) == 32'(ts_reg))
                    begin
                        tsf_next   = 1'b1;
                        state_next = ST_TK_RD;
                    end
                    else
                    begin
                        new_res_next = mk_res(KIND_EXPIRY, 5'(head_reg),
                                              4'(mg_rd[MSG_W-1:32]), mg_rd[31:0]);
                        ret_next     = ST_TK_RD;
                        state_next   = ST_PUSH;
                    end
                end
            end
            ST_TK_END:
            begin
                if (tsf_reg)
                begin
                    new_res_next = mk_res(KIND_SWITCH, 5'(ts_reg), 4'd0, 32'd0);
                    ret_next     = ST_FINISH;
                    state_next   = ST_PUSH;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RF_RD:
            begin
                if (32'(head_reg) < TIMER_SLOTS)
                begin
                    state_next = ST_RF_WAIT;
                end
                else
                begin
                    next_dl_next = NO_DEADLINE;
                    state_next   = post_reg;
                end
            end
            ST_RF_WAIT:
            begin
                next_dl_next = dl_rd;
                state_next   = post_reg;
            end
            ST_AL_SCAN:
            begin
                if (ss_reg[scan_reg] == SS_FREE)
                begin
                    ss_next[scan_reg] = SS_ALLOC;
                    new_res_next = mk_res(KIND_ALLOC, 5'(scan_reg), 4'd0, 32'd0);
                    ret_next     = ST_FINISH;
                    state_next   = ST_PUSH;
                end
                else if (32'(scan_reg) == TIMER_SLOTS - 1)
                begin
                    new_res_next = mk_res(KIND_NOSLOT, 5'd0, 4'd0, 32'd0);
                    ret_next     = ST_FINISH;
                    state_next   = ST_PUSH;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            ST_UL_START:
            begin
                lk_raddr   = s_idx;
                state_next = ST_UL_LS;
            end
            ST_UL_LS:
            begin
                ls_next        = lk_rd;
                ss_next[s_idx] = SS_ALLOC;
                if (active_reg != '0)
                    active_next = active_reg - LW'(1);
                if (head_reg == s_lw)
                begin
                    head_next  = lk_rd;
                    post_next  = ST_UL_DONE;
                    state_next = ST_RF_RD;
                end
                else
                begin
                    ptr_next   = head_reg;
                    walk_next  = '0;
                    state_next = ST_UL_RD;
                end
            end
            ST_UL_RD:
            begin
                lk_raddr = AW'(ptr_reg);
                if (32'(walk_reg) < TIMER_SLOTS && 32'(ptr_reg) < TIMER_SLOTS)
                    state_next = ST_UL_CMP;
                else
                    state_next = ST_UL_DONE;
            end
            ST_UL_CMP:
            begin
                if (lk_rd == s_lw)
                begin
                    lk_we      = 1'b1;
                    lk_waddr   = AW'(ptr_reg);
                    lk_wdata   = ls_reg;
                    state_next = ST_UL_DONE;
                end
                else
                begin
                    ptr_next   = lk_rd;
                    walk_next  = walk_reg + LW'(1);
                    state_next = ST_UL_RD;
                end
            end
            ST_UL_DONE:
            begin
                case (cur_reg.op)
                    OP_FREE:
                    begin
                        ss_next[s_idx] = SS_FREE;
                        state_next     = ST_FINISH;
                    end
                    OP_SET:
                    begin
                        state_next = ST_IN_START;
                    end
                    default:
                    begin
                        new_res_next = mk_res(KIND_CANCEL, cur_reg.slot, 4'd0, 32'd0);
                        ret_next     = ST_FINISH;
                        state_next   = ST_PUSH;
                    end
                endcase
            end
            ST_IN_START:
            begin
                dval_next  = cur_reg.timeout + tc_reg;
                dl_we      = 1'b1;
                dl_wdata   = cur_reg.timeout + tc_reg;
                prev_next  = NULL_IDX;
                ptr_next   = head_reg;
                walk_next  = '0;
                state_next = ST_IN_RD;
            end
            ST_IN_RD:
            begin
                dl_raddr = AW'(ptr_reg);
                lk_raddr = AW'(ptr_reg);
                if (32'(walk_reg) < TIMER_SLOTS && 32'(ptr_reg) < TIMER_SLOTS)
                    state_next = ST_IN_CMP;
                else
                    state_next = ST_IN_LNK;
            end
            ST_IN_CMP:
            begin
                // equal deadlines: the new entry goes in front
                if (dval_reg <= dl_rd)
                begin
                    state_next = ST_IN_LNK;
                end
                else
                begin
                    prev_next  = ptr_reg;
                    ptr_next   = lk_rd;
                    walk_next  = walk_reg + LW'(1);
                    state_next = ST_IN_RD;
                end
            end
            ST_IN_LNK:
            begin
                lk_we      = 1'b1;
                lk_wdata   = (32'(ptr_reg) < TIMER_SLOTS) ? ptr_reg : NULL_IDX;
                state_next = ST_IN_PRV;
            end
            ST_IN_PRV:
            begin
                if (32'(prev_reg) < TIMER_SLOTS)
                begin
                    lk_we    = 1'b1;
                    lk_waddr = AW'(prev_reg);
                    lk_wdata = s_lw;
                end
                else
                begin
                    head_next = s_lw;
                end
                ss_next[s_idx] = SS_RUN;
                active_next    = active_reg + LW'(1);
                post_next      = ST_FINISH;
                state_next     = ST_RF_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            post_reg       <= ST_IDLE;
            cur_reg        <= '0;
            tc_reg         <= '0;
            next_dl_reg    <= NO_DEADLINE;
            dval_reg       <= '0;
            active_reg     <= '0;
            head_reg       <= NULL_IDX;
            ptr_reg        <= '0;
            prev_reg       <= '0;
            ls_reg         <= '0;
            walk_reg       <= '0;
            exp_reg        <= '0;
            ts_reg         <= 6'd32;
            tsf_reg        <= 1'b0;
            scan_reg       <= '0;
            ss_reg         <= '{default: SS_FREE};
            new_res_reg    <= '0;
            hold_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            post_reg       <= post_next;
            cur_reg        <= cur_next;
            tc_reg         <= tc_next;
            next_dl_reg    <= next_dl_next;
            dval_reg       <= dval_next;
            active_reg     <= active_next;
            head_reg       <= head_next;
            ptr_reg        <= ptr_next;
            prev_reg       <= prev_next;
            ls_reg         <= ls_next;
            walk_reg       <= walk_next;
            exp_reg        <= exp_next;
            ts_reg         <= ts_next;
            tsf_reg        <= tsf_next;
            scan_reg       <= scan_next;
            ss_reg         <= ss_next;
            new_res_reg    <= new_res_next;
            hold_reg       <= hold_next;
            hold_valid_reg <= hold_valid_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* design/sorted_timer_pool_core.sv */
// ----------------------------------------------------------------------------
// sorted_timer_pool_core
// Timer slot pool with a deadline-sorted list of running timers.
// ----------------------------------------------------------------------------
// A two-entry command queue decouples input from the execution engine, which
// handles one command at a time. Simple commands (init, free of an idle slot,
// unused codes) pass from decode straight to finish; allocate scans slot
// states at one per cycle; cancel walks the list, reading then comparing
// each entry; set time of a running slot walks twice (unlink, then sorted
// insert); a tick expires slots from the list head, each in turn.
// The list walk rate is set by the registered read of the link and deadline
// memories. Results leave through an output register; the final result of
// each command has last set. No clearing pass is needed after reset.
`default_nettype none

`include "assert_macros.svh"

module sorted_timer_pool_core #(
    parameter int TIMER_SLOTS   = 32,
    parameter int QUEUE_ID_BITS = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire stp_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output stp_pkg::out_item_t      out_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [5:0]         cfg_data
);
    import stp_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    stp_front #(.TIMER_SLOTS(TIMER_SLOTS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    stp_back #(.TIMER_SLOTS(TIMER_SLOTS), .QUEUE_ID_BITS(QUEUE_ID_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    // engine never pops an empty queue
    `ASSERT_CLK(a_take_has_cmd, cmd_take |-> cmd_valid)
    // the engine never takes a command in the cycle after taking one
    `ASSERT_CLK(a_take_spaced, cmd_take |=> !cmd_take)

endmodule

`default_nettype wire
